[hw/rtl/mtfd_pkg.sv]
package mtfd_pkg;

    localparam int NUM_TENANTS = 8;
    localparam int QUEUE_SLOTS = 32;
    localparam int MAX_WORKERS = 8;
    localparam int KEY_BITS    = 16;
    localparam int TW          = 3;    // tenant index
    localparam int RUNW        = 4;    // running counters
    localparam int STAMPW      = 32;

    localparam logic [2:0] ST_QUEUED     = 3'd0;
    localparam logic [2:0] ST_DUPLICATE  = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_DISPATCHED = 3'd3;
    localparam logic [2:0] ST_NONE_READY = 3'd4;
    localparam logic [2:0] ST_COMPLETED  = 3'd5;
    localparam logic [2:0] ST_CANCELLED  = 3'd6;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd7;

    localparam logic [1:0] FN_SUBMIT   = 2'd0;
    localparam logic [1:0] FN_DISPATCH = 2'd1;
    localparam logic [1:0] FN_COMPLETE = 2'd2;
    localparam logic [1:0] FN_CANCEL   = 2'd3;

    localparam logic [1:0] CFG_WORKERS   = 2'd0;
    localparam logic [1:0] CFG_RUN_LIM   = 2'd1;
    localparam logic [1:0] CFG_TOTAL_LIM = 2'd2;
    localparam logic [1:0] CFG_PEND_LIM  = 2'd3;

    typedef struct packed {
        logic [TW-1:0]       tenant;
        logic [KEY_BITS-1:0] key;
        logic [STAMPW-1:0]   stamp;
    } t_slot;

endpackage

[hw/rtl/mtfd_slot_mem.sv]
module mtfd_slot_mem #(
    parameter int QUEUE_SLOTS = mtfd_pkg::QUEUE_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(QUEUE_SLOTS)-1:0] i_waddr,
    input  mtfd_pkg::t_slot                i_wdata,
    input  logic [$clog2(QUEUE_SLOTS)-1:0] i_raddr,
    output mtfd_pkg::t_slot                o_rdata
);

    mtfd_pkg::t_slot r_mem [QUEUE_SLOTS];
    mtfd_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/multi_tenant_fair_dispatcher_unit.sv]
// Submit and cancel sweep the whole slot table; complete only searches the running table.
// Dispatch: answers none-ready without popping when no worker is free, else pops ready-ring entries
//   and sweeps the slot table once per tenant scanned, through its single read port.
// Throughput: one item at a time; the next item is taken once the result is in the output register.
// Reset (i_rst_n low, synchronous): all queues, counters and the ready ring empty; configuration
//   registers return to their defaults. No clearing pass: slot entries are covered by valid flops.
module multi_tenant_fair_dispatcher_unit #(
    parameter int QUEUE_SLOTS = mtfd_pkg::QUEUE_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // tenant[2:0], job_key[18:3], zero
    input  logic [1:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_tenant[2:0], out_key[18:3],
                                        // pending_total[24:19], running_total[28:25], zero
    output logic [2:0]  m_axis_tuser,   // status
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [5:0]  i_cfg_data
);

    localparam int SW   = $clog2(QUEUE_SLOTS);
    localparam int PW   = $clog2(QUEUE_SLOTS + 1);
    localparam int NT   = mtfd_pkg::NUM_TENANTS;
    localparam int MW   = mtfd_pkg::MAX_WORKERS;
    localparam int TW   = mtfd_pkg::TW;
    localparam int KW   = mtfd_pkg::KEY_BITS;
    localparam int RUNW = mtfd_pkg::RUNW;
    localparam int STW  = mtfd_pkg::STAMPW;
    localparam int RIW  = $clog2(MW);
    localparam logic [SW-1:0] LAST = SW'(QUEUE_SLOTS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_READY = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state;

    logic [3:0] r_workers;
    logic [2:0] r_run_lim;
    logic [5:0] r_total_lim;
    logic [4:0] r_pend_lim;

    logic [1:0]    r_func;
    logic [TW-1:0] r_t;
    logic [KW-1:0] r_k;
    logic [2:0]    r_status;
    logic [TW-1:0] r_res_t;
    logic [KW-1:0] r_res_k;

    logic [QUEUE_SLOTS-1:0] r_slot_valid;
    logic [STW-1:0]         r_arrival;
    logic [MW-1:0]          r_run_valid;
    logic [TW-1:0]          r_run_t [MW];
    logic [KW-1:0]          r_run_k [MW];
    logic [PW-1:0]          r_tpend [NT];
    logic [RUNW-1:0]        r_trun [NT];
    logic [NT-1:0]          r_in_ring;
    logic [TW-1:0]          r_ring [NT];
    logic [TW-1:0]          r_head;
    logic [TW:0]            r_rcount;
    logic [PW-1:0]          r_pending;
    logic [RUNW-1:0]        r_running;
    logic [RIW-1:0]         r_run_free;

    // sweep
    logic          r_issue;
    logic [SW-1:0] r_idx;
    logic          r_rd_vld;
    logic [SW-1:0] r_rd_idx;
    logic          r_free_found;
    logic [SW-1:0] r_free_idx;
    logic          r_hit;
    logic [SW-1:0] r_hit_idx;
    logic          r_best_found;
    logic [SW-1:0] r_best_idx;
    logic [STW-1:0] r_best_age;
    logic [KW-1:0] r_best_key;

    logic          r_ov;
    logic [2:0]    r_o_status;
    logic [TW-1:0] r_o_t;
    logic [KW-1:0] r_o_k;
    logic [5:0]    r_o_pend;
    logic [3:0]    r_o_run;

    logic            mem_we;
    mtfd_pkg::t_slot mem_wdata;
    mtfd_pkg::t_slot mem_rdata;

    mtfd_slot_mem #(.QUEUE_SLOTS(QUEUE_SLOTS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_free_idx),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    // running table lookup and free entry
    logic           run_hit;
    logic [RIW-1:0] run_hit_idx;
    logic           run_free;
    logic [RIW-1:0] run_free_idx;
    always_comb begin
        run_hit = 1'b0;
        run_hit_idx = '0;
        run_free = 1'b0;
        run_free_idx = '0;
        for (int i = MW - 1; i >= 0; i--) begin
            if (r_run_valid[i] && r_run_t[i] == r_t && r_run_k[i] == r_k) begin
                run_hit = 1'b1;
                run_hit_idx = RIW'(i);
            end
            if (!r_run_valid[i]) begin
                run_free = 1'b1;
                run_free_idx = RIW'(i);
            end
        end
    end

    logic [3:0] bound;
    assign bound = (r_workers < 4'(MW)) ? r_workers : 4'(MW);

    logic [STW-1:0] rd_age;
    logic           rd_v;
    assign rd_age = r_arrival - mem_rdata.stamp;
    assign rd_v   = r_slot_valid[r_rd_idx];

    logic [TW-1:0] pop_t;
    logic          pop_blocked;
    assign pop_t = r_ring[r_head];
    assign pop_blocked = (r_trun[pop_t] >= RUNW'(r_run_lim)) || (r_tpend[pop_t] == '0);

    logic [TW-1:0] tail;
    assign tail = r_head + r_rcount[TW-1:0];

    logic submit_full;
    assign submit_full = (32'(r_pending) >= 32'(r_total_lim)) ||
                         (32'(r_tpend[r_t]) >= 32'(r_pend_lim)) || !r_free_found;

    // slot is written only when the submit is accepted
    assign mem_we = (r_state == S_APPLY) && (r_func == mtfd_pkg::FN_SUBMIT) &&
                    !r_hit && !run_hit && !submit_full;
    assign mem_wdata = '{tenant: r_t, key: r_k, stamp: r_arrival};

    logic out_free;
    assign out_free = !r_ov || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_workers    <= 4'd4;
            r_run_lim    <= 3'd1;
            r_total_lim  <= 6'd32;
            r_pend_lim   <= 5'd8;
            r_slot_valid <= '0;
            r_arrival    <= '0;
            r_run_valid  <= '0;
            r_in_ring    <= '0;
            r_head       <= '0;
            r_rcount     <= '0;
            r_pending    <= '0;
            r_running    <= '0;
            r_issue      <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_ov         <= 1'b0;
            for (int i = 0; i < NT; i++) begin
                r_tpend[i] <= '0;
                r_trun[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mtfd_pkg::CFG_WORKERS:   r_workers   <= i_cfg_data[3:0];
                    mtfd_pkg::CFG_RUN_LIM:   r_run_lim   <= i_cfg_data[2:0];
                    mtfd_pkg::CFG_TOTAL_LIM: r_total_lim <= i_cfg_data;
                    mtfd_pkg::CFG_PEND_LIM:  r_pend_lim  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            // S_OUT reloads the output register itself
            if (r_ov && m_axis_tready && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end

            // read pipeline of the sweep
            r_rd_vld <= r_issue;
            r_rd_idx <= r_idx;
            if (r_issue) begin
                if (r_idx == LAST) begin
                    r_issue <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_func  <= s_axis_tuser;
                        r_t     <= s_axis_tdata[TW-1:0];
                        r_k     <= s_axis_tdata[TW+KW-1:TW];
                        r_res_t <= s_axis_tdata[TW-1:0];
                        r_res_k <= s_axis_tdata[TW+KW-1:TW];
                        r_free_found <= 1'b0;
                        r_hit        <= 1'b0;
                        r_best_found <= 1'b0;
                        unique case (s_axis_tuser) inside
                            mtfd_pkg::FN_SUBMIT, mtfd_pkg::FN_CANCEL: begin
                                r_idx   <= '0;
                                r_issue <= 1'b1;
                                r_state <= S_SCAN;
                            end
                            mtfd_pkg::FN_COMPLETE: r_state <= S_APPLY;
                            default: begin
                                if (r_running < bound && run_free) begin
                                    r_run_free <= run_free_idx;
                                    r_state    <= S_POP;
                                end else begin
                                    r_status <= mtfd_pkg::ST_NONE_READY;
                                    r_state  <= S_OUT;
                                end
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_rd_vld) begin
                        if (!rd_v && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_rd_idx;
                        end
                        if (rd_v && mem_rdata.tenant == r_t) begin
                            if (mem_rdata.key == r_k && !r_hit) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= r_rd_idx;
                            end
                            if (!r_best_found || rd_age > r_best_age) begin
                                r_best_found <= 1'b1;
                                r_best_idx   <= r_rd_idx;
                                r_best_age   <= rd_age;
                                r_best_key   <= mem_rdata.key;
                            end
                        end
                        if (r_rd_idx == LAST) begin
                            r_state <= S_APPLY;
                            if (r_func == mtfd_pkg::FN_SUBMIT) begin
                                // queued is preset here; S_APPLY overrides it if the submit is refused
                                r_status <= mtfd_pkg::ST_QUEUED;
                            end
                        end
                    end
                end
                S_APPLY: begin
                    r_state <= S_OUT;
                    unique case (r_func)
                        mtfd_pkg::FN_SUBMIT: begin
                            // r_status still holds queued here; duplicate wins over limits
                            if (r_hit || run_hit) begin
                                r_status <= mtfd_pkg::ST_DUPLICATE;
                            end else if (submit_full) begin
                                r_status <= mtfd_pkg::ST_FULL;
                            end else begin
                                r_slot_valid[r_free_idx] <= 1'b1;
                                r_arrival  <= r_arrival + 1'b1;
                                r_tpend[r_t] <= r_tpend[r_t] + 1'b1;
                                r_pending  <= r_pending + 1'b1;
                                r_state    <= S_READY;
                            end
                        end
                        mtfd_pkg::FN_CANCEL: begin
                            if (r_hit) begin
                                r_slot_valid[r_hit_idx] <= 1'b0;
                                if (r_tpend[r_t] != '0) r_tpend[r_t] <= r_tpend[r_t] - 1'b1;
                                if (r_pending != '0) r_pending <= r_pending - 1'b1;
                                r_status <= mtfd_pkg::ST_CANCELLED;
                            end else begin
                                r_status <= mtfd_pkg::ST_NOT_FOUND;
                            end
                        end
                        mtfd_pkg::FN_COMPLETE: begin
                            if (run_hit) begin
                                r_run_valid[run_hit_idx] <= 1'b0;
                                if (r_trun[r_t] != '0) r_trun[r_t] <= r_trun[r_t] - 1'b1;
                                if (r_running != '0) r_running <= r_running - 1'b1;
                                r_status <= mtfd_pkg::ST_COMPLETED;
                                r_state  <= S_READY;
                            end else begin
                                r_status <= mtfd_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (r_best_found) begin
                                r_slot_valid[r_best_idx] <= 1'b0;
                                r_tpend[r_t] <= r_tpend[r_t] - 1'b1;
                                r_pending    <= r_pending - 1'b1;
                                r_run_valid[r_run_free] <= 1'b1;
                                r_run_t[r_run_free] <= r_t;
                                r_run_k[r_run_free] <= r_best_key;
                                r_trun[r_t]  <= r_trun[r_t] + 1'b1;
                                r_running    <= r_running + 1'b1;
                                r_res_t      <= r_t;
                                r_res_k      <= r_best_key;
                                r_status     <= mtfd_pkg::ST_DISPATCHED;
                                r_state      <= S_READY;
                            end else begin
                                r_state <= S_POP;
                            end
                        end
                    endcase
                end
                S_POP: begin
                    if (r_rcount == '0) begin
                        r_status <= mtfd_pkg::ST_NONE_READY;
                        r_state  <= S_OUT;
                    end else begin
                        r_head   <= r_head + 1'b1;
                        r_rcount <= r_rcount - 1'b1;
                        r_in_ring[pop_t] <= 1'b0;
                        if (!pop_blocked) begin
                            r_t          <= pop_t;
                            r_best_found <= 1'b0;
                            r_idx        <= '0;
                            r_issue      <= 1'b1;
                            r_state      <= S_SCAN;
                        end
                    end
                end
                S_READY: begin
                    if (!r_in_ring[r_t] && r_trun[r_t] < RUNW'(r_run_lim) &&
                        r_tpend[r_t] != '0 && r_rcount < (TW+1)'(NT)) begin
                        r_in_ring[r_t] <= 1'b1;
                        r_ring[tail]   <= r_t;
                        r_rcount       <= r_rcount + 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ov       <= 1'b1;
                        r_o_status <= r_status;
                        r_o_t      <= r_res_t;
                        r_o_k      <= r_res_k;
                        r_o_pend   <= 6'(r_pending);
                        r_o_run    <= r_running;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {3'b000, r_o_run, r_o_pend, r_o_k, r_o_t};

`ifndef SYNTHESIS
    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_run_valid) == 32'(r_running))
        else $error("running count out of step with running table");
    a_pend_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_slot_valid) == 32'(r_pending))
        else $error("pending count out of step with slot valid bits");
    a_ring_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_in_ring) == 32'(r_rcount))
        else $error("ready ring count out of step with ring membership");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !out_free) |=> (r_state == S_OUT))
        else $error("result lost while output busy");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  tenant;
        logic [15:0] key;
        logic [5:0]  pend;
        logic [3:0]  run;
    } t_disp_result;

    // Software copy of the dispatcher; tracks queue, running table and ready ring.
    class t_scoreboard;
        logic [3:0]  workers;
        logic [2:0]  run_lim;
        logic [5:0]  total_lim;
        logic [4:0]  pend_lim;
        bit          q_vld[mtfd_pkg::QUEUE_SLOTS];
        logic [2:0]  q_ten[mtfd_pkg::QUEUE_SLOTS];
        logic [15:0] q_key[mtfd_pkg::QUEUE_SLOTS];
        logic [31:0] q_stamp[mtfd_pkg::QUEUE_SLOTS];
        logic [31:0] arrivals;
        bit          w_vld[mtfd_pkg::MAX_WORKERS];
        logic [2:0]  w_ten[mtfd_pkg::MAX_WORKERS];
        logic [15:0] w_key[mtfd_pkg::MAX_WORKERS];
        int          ten_pend[mtfd_pkg::NUM_TENANTS];
        int          ten_run[mtfd_pkg::NUM_TENANTS];
        bit          in_ring[mtfd_pkg::NUM_TENANTS];
        logic [2:0]  ring[mtfd_pkg::NUM_TENANTS];
        int          head, cnt, pend_cnt, run_cnt;
        t_disp_result expected_q[$];
        int          mismatches;

        function void clear();
            workers = 4'd4; run_lim = 3'd1; total_lim = 6'd32; pend_lim = 5'd8;
            foreach (q_vld[i]) q_vld[i] = 0;
            foreach (w_vld[i]) w_vld[i] = 0;
            foreach (ten_pend[i]) begin
                ten_pend[i] = 0; ten_run[i] = 0; in_ring[i] = 0; ring[i] = '0;
            end
            arrivals = '0; head = 0; cnt = 0; pend_cnt = 0; run_cnt = 0;
            expected_q.delete();
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [5:0] val);
            case (idx)
                mtfd_pkg::CFG_WORKERS:   workers = val[3:0];
                mtfd_pkg::CFG_RUN_LIM:   run_lim = val[2:0];
                mtfd_pkg::CFG_TOTAL_LIM: total_lim = val;
                mtfd_pkg::CFG_PEND_LIM:  pend_lim = val[4:0];
                default: ;
            endcase
        endfunction

        function int find_q(logic [2:0] t, logic [15:0] k);
            for (int i = 0; i < mtfd_pkg::QUEUE_SLOTS; i++)
                if (q_vld[i] && q_ten[i] == t && q_key[i] == k) return i;
            return -1;
        endfunction

        function int find_w(logic [2:0] t, logic [15:0] k);
            for (int i = 0; i < mtfd_pkg::MAX_WORKERS; i++)
                if (w_vld[i] && w_ten[i] == t && w_key[i] == k) return i;
            return -1;
        endfunction

        function void enroll(logic [2:0] t);
            if (!in_ring[t] && ten_run[t] < run_lim && ten_pend[t] != 0
                && cnt < mtfd_pkg::NUM_TENANTS) begin
                in_ring[t] = 1;
                ring[(head + cnt) % mtfd_pkg::NUM_TENANTS] = t;
                cnt++;
            end
        endfunction

        function void note_item(logic [1:0] fn, logic [2:0] t, logic [15:0] k);
            t_disp_result r;
            int s, w, bound, best;
            logic [31:0] age, best_age;
            logic [2:0] tt;
            r.tenant = t; r.key = k;
            case (fn)
                mtfd_pkg::FN_SUBMIT: begin
                    s = -1;
                    if (find_q(t, k) >= 0 || find_w(t, k) >= 0)
                        r.status = mtfd_pkg::ST_DUPLICATE;
                    else if (pend_cnt >= total_lim || ten_pend[t] >= pend_lim)
                        r.status = mtfd_pkg::ST_FULL;
                    else begin
                        for (int i = 0; i < mtfd_pkg::QUEUE_SLOTS; i++)
                            if (!q_vld[i] && s < 0) s = i;
                        if (s < 0) r.status = mtfd_pkg::ST_FULL;
                        else begin
                            q_vld[s] = 1; q_ten[s] = t; q_key[s] = k;
                            q_stamp[s] = arrivals; arrivals++;
                            ten_pend[t]++; pend_cnt++;
                            enroll(t);
                            r.status = mtfd_pkg::ST_QUEUED;
                        end
                    end
                end
                mtfd_pkg::FN_DISPATCH: begin
                    r.status = mtfd_pkg::ST_NONE_READY;
                    bound = (workers < 4'(mtfd_pkg::MAX_WORKERS)) ? int'(workers)
                            : mtfd_pkg::MAX_WORKERS;
                    w = -1;
                    for (int i = 0; i < mtfd_pkg::MAX_WORKERS; i++)
                        if (!w_vld[i] && w < 0) w = i;
                    if (run_cnt < bound && w >= 0) begin
                        while (cnt != 0 && r.status != mtfd_pkg::ST_DISPATCHED) begin
                            tt = ring[head];
                            head = (head + 1) % mtfd_pkg::NUM_TENANTS;
                            cnt--;
                            in_ring[tt] = 0;
                            if (ten_run[tt] < run_lim && ten_pend[tt] != 0) begin
                                best = -1; best_age = '0;
                                for (int i = 0; i < mtfd_pkg::QUEUE_SLOTS; i++)
                                    if (q_vld[i] && q_ten[i] == tt) begin
                                        age = arrivals - q_stamp[i];
                                        if (best < 0 || age > best_age) begin
                                            best = i; best_age = age;
                                        end
                                    end
                                if (best >= 0) begin
                                    q_vld[best] = 0; ten_pend[tt]--; pend_cnt--;
                                    w_vld[w] = 1; w_ten[w] = tt; w_key[w] = q_key[best];
                                    ten_run[tt]++; run_cnt++;
                                    enroll(tt);
                                    r.status = mtfd_pkg::ST_DISPATCHED;
                                    r.tenant = tt; r.key = q_key[best];
                                end
                            end
                        end
                    end
                end
                mtfd_pkg::FN_COMPLETE: begin
                    w = find_w(t, k);
                    if (w < 0) r.status = mtfd_pkg::ST_NOT_FOUND;
                    else begin
                        w_vld[w] = 0;
                        if (ten_run[t] != 0) ten_run[t]--;
                        if (run_cnt != 0) run_cnt--;
                        enroll(t);
                        r.status = mtfd_pkg::ST_COMPLETED;
                    end
                end
                default: begin
                    s = find_q(t, k);
                    if (s < 0) r.status = mtfd_pkg::ST_NOT_FOUND;
                    else begin
                        q_vld[s] = 0;
                        if (ten_pend[t] != 0) ten_pend[t]--;
                        if (pend_cnt != 0) pend_cnt--;
                        r.status = mtfd_pkg::ST_CANCELLED;
                    end
                end
            endcase
            r.pend = 6'(pend_cnt); r.run = 4'(run_cnt);
            expected_q.push_back(r);
        endfunction

        function void check_result(t_disp_result got);
            t_disp_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = 0;
    logic [1:0]  s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = 0;
    logic [5:0]  i_cfg_data = 0;

    multi_tenant_fair_dispatcher_unit dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    t_scoreboard sb = new();
    int  hold_off = 0;
    int  idle_cycles = 0;
    bit  wd_expired = 0;
    // An eight-entry key pool shared by all tenants keeps duplicates, completes and cancels hitting live jobs.
    logic [15:0] key_pool[8];

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result({m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[18:3],
                             m_axis_tdata[24:19], m_axis_tdata[28:25]});
    end

    // Result side: random stalls, plus a long hold-off when asked.
    initial begin
        int w;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off > 0) begin
                m_axis_tready <= 0;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (w > 0) begin
                m_axis_tready <= 0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) wd_expired = 1;
    end

    task automatic send_item(logic [1:0] fn, logic [2:0] t, logic [15:0] k, int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {5'd0, k, t};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(fn, t, k);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [5:0] val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        logic [1:0]  fn;
        logic [2:0]  t;
        logic [15:0] k;
        int gap;
        for (int i = 0; i < n; i++) begin
            fn = 2'($urandom_range(0, 3));
            t  = 3'($urandom_range(0, 7));
            k  = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                 : key_pool[$urandom_range(0, 7)];
            gap = (i % 100 < 30) ? 0 : $urandom_range(0, 9);
            send_item(fn, t, k, gap);
        end
    endtask

    initial begin
        sb.clear();
        foreach (key_pool[i]) key_pool[i] = 16'($urandom);
        key_pool[0] = 16'h0000; key_pool[1] = 16'hFFFF;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        fork
            begin
                // Directed: every operation, extremes, duplicates, limits, cancel of running.
                send_item(mtfd_pkg::FN_DISPATCH, 3'd0, 16'h1234, 0);
                send_item(mtfd_pkg::FN_SUBMIT, 3'd0, 16'h0000, 0);
                send_item(mtfd_pkg::FN_SUBMIT, 3'd0, 16'h0000, 0);
                send_item(mtfd_pkg::FN_SUBMIT, 3'd7, 16'hFFFF, 0);
                send_item(mtfd_pkg::FN_SUBMIT, 3'd7, 16'hAAAA, 0);
                send_item(mtfd_pkg::FN_SUBMIT, 3'd7, 16'h5555, 0);
                send_item(mtfd_pkg::FN_DISPATCH, 3'd5, 16'h0, 0);
                send_item(mtfd_pkg::FN_CANCEL, 3'd0, 16'h0000, 0);
                send_item(mtfd_pkg::FN_SUBMIT, 3'd0, 16'h0000, 0);
                send_item(mtfd_pkg::FN_DISPATCH, 3'd0, 16'h0, 0);
                send_item(mtfd_pkg::FN_DISPATCH, 3'd0, 16'h0, 0);
                send_item(mtfd_pkg::FN_SUBMIT, 3'd0, 16'h0000, 0);
                send_item(mtfd_pkg::FN_CANCEL, 3'd7, 16'hFFFF, 0);
                send_item(mtfd_pkg::FN_CANCEL, 3'd0, 16'h0000, 0);
                send_item(mtfd_pkg::FN_COMPLETE, 3'd3, 16'h0001, 0);
                send_item(mtfd_pkg::FN_COMPLETE, 3'd7, 16'hFFFF, 0);
                send_item(mtfd_pkg::FN_DISPATCH, 3'd0, 16'h0, 0);
                send_item(mtfd_pkg::FN_COMPLETE, 3'd0, 16'h0000, 0);
                send_item(mtfd_pkg::FN_CANCEL, 3'd7, 16'h5555, 0);
                drain();

                random_phase(400);
                drain();
                // Extremes: tight limits.
                set_reg(mtfd_pkg::CFG_WORKERS, 6'd2);
                set_reg(mtfd_pkg::CFG_RUN_LIM, 6'd1);
                set_reg(mtfd_pkg::CFG_TOTAL_LIM, 6'd2);
                set_reg(mtfd_pkg::CFG_PEND_LIM, 6'd1);
                random_phase(300);
                drain();
                // Widest limits; the receiver stalls long so the input backs up.
                set_reg(mtfd_pkg::CFG_WORKERS, 6'd8);
                set_reg(mtfd_pkg::CFG_RUN_LIM, 6'd7);
                set_reg(mtfd_pkg::CFG_TOTAL_LIM, 6'd32);
                set_reg(mtfd_pkg::CFG_PEND_LIM, 6'd31);
                hold_off = 400;
                random_phase(400);
                drain();
                // Beyond the table, and zero limits.
                set_reg(mtfd_pkg::CFG_WORKERS, 6'd15);
                set_reg(mtfd_pkg::CFG_RUN_LIM, 6'd0);
                set_reg(mtfd_pkg::CFG_TOTAL_LIM, 6'd63);
                set_reg(mtfd_pkg::CFG_PEND_LIM, 6'd0);
                random_phase(180);
                drain();
                set_reg(mtfd_pkg::CFG_WORKERS, 6'd3);
                set_reg(mtfd_pkg::CFG_RUN_LIM, 6'd2);
                set_reg(mtfd_pkg::CFG_TOTAL_LIM, 6'd20);
                set_reg(mtfd_pkg::CFG_PEND_LIM, 6'd31);
                random_phase(400);
                drain();
            end
            begin
                wait (wd_expired);
            end
        join_any

        if (wd_expired) begin
            $display("multi_tenant_fair_dispatcher_unit regression: fail");
            $finish;
        end else begin
            if (sb.mismatches == 0 && sb.expected_q.size() == 0)
                $display("multi_tenant_fair_dispatcher_unit regression: pass");
            else
                $display("multi_tenant_fair_dispatcher_unit regression: fail");
            $finish;
        end
    end
endmodule
